[hdl/qnor_pkg.sv]
package qnor_pkg;

  localparam int unsigned MAX_ORDER = 15;

  localparam int unsigned ORDER_W  = 4;
  localparam int unsigned HANDLE_W = 16;
  localparam int unsigned SLOT_W   = 8;
  localparam int unsigned POS_W    = 4;
  localparam int unsigned CNT_W    = 8;
  localparam int unsigned NUM_SEG  = 6;

  // segments of one ring, in walk order
  typedef enum logic [2:0] {
    SEG_BOT_VTX    = 3'd0,
    SEG_TOP_VTX    = 3'd1,
    SEG_BOT_EDGE   = 3'd2,
    SEG_RIGHT_EDGE = 3'd3,
    SEG_TOP_EDGE   = 3'd4,
    SEG_LEFT_EDGE  = 3'd5,
    SEG_CENTER     = 3'd6
  } seg_e;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic              last;
  } walk_res_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] node_handle_out;
    logic [SLOT_W-1:0]   tensor_slot;
    logic                last_node;
  } node_res_t;

  // order zero counts as one; clamp to the supported maximum
  function automatic logic [ORDER_W-1:0] eff_order(input logic [ORDER_W-1:0] ord);
    logic [ORDER_W-1:0] n;
    n = ord;
    if (n == '0) begin
      n = ORDER_W'(1);
    end
    if (n > ORDER_W'(MAX_ORDER)) begin
      n = ORDER_W'(MAX_ORDER);
    end
    return n;
  endfunction

endpackage

[hdl/qnor_in_if.sv]
interface qnor_in_if;
  import qnor_pkg::*;

  logic                valid;
  logic                ready;
  logic [HANDLE_W-1:0] node_handle;

  modport source (output valid, output node_handle, input ready);
  modport sink   (input valid, input node_handle, output ready);

endinterface

[hdl/qnor_out_if.sv]
interface qnor_out_if;
  import qnor_pkg::*;

  logic                valid;
  logic                ready;
  logic [HANDLE_W-1:0] node_handle_out;
  logic [SLOT_W-1:0]   tensor_slot;
  logic                last_node;

  modport source (output valid, output node_handle_out, output tensor_slot,
                  output last_node, input ready);
  modport sink   (input valid, input node_handle_out, input tensor_slot,
                  input last_node, output ready);

endinterface

[hdl/qnor_walk.sv]
module qnor_walk
  import qnor_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  logic               cfg_we_i,
  input  logic [ORDER_W-1:0] cfg_wdata_i,
  output walk_res_t          res_o
);

  logic [ORDER_W-1:0] order_q, order_d;
  logic [ORDER_W-1:0] span_q, span_d;
  seg_e               sel_q, sel_d;
  logic [POS_W-1:0]   pos_q, pos_d;
  logic [SLOT_W-1:0]  start_q [NUM_SEG];
  logic [SLOT_W-1:0]  start_d [NUM_SEG];
  logic [CNT_W-1:0]   cnt_q, cnt_d;

  logic [ORDER_W-1:0] n;
  logic [ORDER_W:0]   side;
  logic [9:0]         sq;
  logic [SLOT_W-1:0]  sq_m1;
  logic [SLOT_W-1:0]  pk;
  logic [8:0]         pside;
  logic [SLOT_W-1:0]  slot;
  logic               last;

  logic [ORDER_W-1:0] rw_n;
  logic [ORDER_W:0]   rw_side;
  logic [9:0]         rw_sq;
  logic [SLOT_W-1:0]  rw_side8;
  logic [SLOT_W-1:0]  rw_start [NUM_SEG];

  logic [POS_W:0]     pos_inc;
  logic [POS_W:0]     cur_len;
  logic               nxt_found;
  seg_e               nxt_sel;
  logic [SLOT_W-1:0]  ring_step;
  logic [SLOT_W-1:0]  n8;

  function automatic logic [POS_W-1:0] seg_len(input seg_e s, input logic [ORDER_W-1:0] k);
    logic [POS_W-1:0] len;
    len = '0;
    case (s)
      SEG_BOT_VTX, SEG_TOP_VTX: len = POS_W'(2);
      SEG_BOT_EDGE, SEG_RIGHT_EDGE, SEG_TOP_EDGE, SEG_LEFT_EDGE:
        len = (k == '0) ? '0 : k - ORDER_W'(1);
      SEG_CENTER: len = (k == ORDER_W'(2)) ? POS_W'(1) : '0;
      default: len = '0;
    endcase
    return len;
  endfunction

  // geometry of the current element
  assign n     = eff_order(order_q);
  assign side  = {1'b0, n} + (ORDER_W+1)'(1);
  assign sq    = {5'b0, side} * {5'b0, side};
  assign sq_m1 = sq[SLOT_W-1:0] - SLOT_W'(1);
  assign pk    = {4'b0, pos_q} * {4'b0, span_q};
  assign pside = {5'b0, pos_q} * {4'b0, side};
  assign n8    = {4'b0, n};
  assign ring_step = n8 + SLOT_W'(2);

  always_comb begin
    case (sel_q)
      SEG_BOT_VTX:    slot = start_q[0] + pk;
      SEG_TOP_VTX:    slot = start_q[1] - pk;
      SEG_BOT_EDGE:   slot = start_q[2] + {4'b0, pos_q};
      SEG_RIGHT_EDGE: slot = start_q[3] + pside[SLOT_W-1:0];
      SEG_TOP_EDGE:   slot = start_q[4] - {4'b0, pos_q};
      SEG_LEFT_EDGE:  slot = start_q[5] - pside[SLOT_W-1:0];
      default:        slot = start_q[5] + SLOT_W'(1);
    endcase
  end

  assign last  = (cnt_q == sq_m1);
  assign res_o = '{slot: slot, last: last};

  // start positions of the outer ring, for the order in force after this cycle
  assign rw_n     = eff_order(cfg_we_i ? cfg_wdata_i : order_q);
  assign rw_side  = {1'b0, rw_n} + (ORDER_W+1)'(1);
  assign rw_sq    = {5'b0, rw_side} * {5'b0, rw_side};
  assign rw_side8 = {3'b0, rw_side};

  always_comb begin
    rw_start[0] = '0;
    rw_start[1] = rw_sq[SLOT_W-1:0] - SLOT_W'(1);
    rw_start[2] = SLOT_W'(1);
    rw_start[3] = (rw_side8 << 1) - SLOT_W'(1);
    rw_start[4] = rw_sq[SLOT_W-1:0] - SLOT_W'(2);
    rw_start[5] = rw_sq[SLOT_W-1:0] - (rw_side8 << 1);
  end

  // first non-empty segment after the current one
  assign pos_inc = {1'b0, pos_q} + (POS_W+1)'(1);
  assign cur_len = {1'b0, seg_len(sel_q, span_q)};

  always_comb begin
    nxt_found = 1'b0;
    nxt_sel   = SEG_BOT_VTX;
    for (int i = 6; i >= 1; i--) begin
      if (3'(i) > sel_q && seg_len(seg_e'(3'(i)), span_q) != '0) begin
        nxt_found = 1'b1;
        nxt_sel   = seg_e'(3'(i));
      end
    end
  end

  always_comb begin
    order_d = order_q;
    span_d  = span_q;
    sel_d   = sel_q;
    pos_d   = pos_q;
    cnt_d   = cnt_q;
    for (int s = 0; s < NUM_SEG; s++) begin
      start_d[s] = start_q[s];
    end

    if (cfg_we_i || (step_i && last)) begin
      if (cfg_we_i) begin
        order_d = cfg_wdata_i;
      end
      span_d = rw_n;
      sel_d  = SEG_BOT_VTX;
      pos_d  = '0;
      cnt_d  = '0;
      for (int s = 0; s < NUM_SEG; s++) begin
        start_d[s] = rw_start[s];
      end
    end else if (step_i) begin
      cnt_d = cnt_q + CNT_W'(1);
      if (pos_inc < cur_len) begin
        pos_d = pos_inc[POS_W-1:0];
      end else begin
        pos_d = '0;
        if (nxt_found) begin
          sel_d = nxt_sel;
        end else if (span_q < ORDER_W'(3)) begin
          // walk overrun: back to the outer ring
          span_d = rw_n;
          sel_d  = SEG_BOT_VTX;
          cnt_d  = '0;
          for (int s = 0; s < NUM_SEG; s++) begin
            start_d[s] = rw_start[s];
          end
        end else begin
          // step to the next inner ring
          span_d     = span_q - ORDER_W'(2);
          sel_d      = SEG_BOT_VTX;
          start_d[0] = start_q[0] + ring_step;
          start_d[1] = start_q[1] - ring_step;
          start_d[2] = start_q[0] + ring_step + SLOT_W'(1);
          start_d[3] = start_q[3] + n8;
          start_d[4] = start_q[1] - ring_step - SLOT_W'(1);
          start_d[5] = start_q[5] - n8;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q    <= ORDER_W'(1);
      span_q     <= ORDER_W'(1);
      sel_q      <= SEG_BOT_VTX;
      pos_q      <= '0;
      cnt_q      <= '0;
      start_q[0] <= SLOT_W'(0);
      start_q[1] <= SLOT_W'(3);
      start_q[2] <= SLOT_W'(1);
      start_q[3] <= SLOT_W'(3);
      start_q[4] <= SLOT_W'(2);
      start_q[5] <= SLOT_W'(0);
    end else begin
      order_q <= order_d;
      span_q  <= span_d;
      sel_q   <= sel_d;
      pos_q   <= pos_d;
      cnt_q   <= cnt_d;
      for (int s = 0; s < NUM_SEG; s++) begin
        start_q[s] <= start_d[s];
      end
    end
  end

endmodule

[hdl/quad_node_order_remap.sv]
// An accepted word goes to the output register, or to the skid under a stall.
// Throughput: one node per cycle; the walk position register updates once per
// accepted node. Under an output stall a two-word stage takes one more word,
// then input closes until the held word is taken.
// Reset: order 1, walk at the start of the outer ring, output stage empty.
// A write to the order register rewinds the walk to a new element.
module quad_node_order_remap
  import qnor_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  qnor_in_if.sink            node_i,
  qnor_out_if.source         result_o,
  input  logic               cfg_we_i,
  input  logic [ORDER_W-1:0] cfg_wdata_i
);

  walk_res_t walk_res;
  node_res_t new_word;
  node_res_t main_q, main_d;
  node_res_t skid_q, skid_d;
  logic      main_v_q, main_v_d;
  logic      skid_v_q, skid_v_d;
  logic      accept;
  logic      take;

  assign node_i.ready = !skid_v_q;
  assign accept       = node_i.valid && !skid_v_q;
  assign take         = main_v_q && result_o.ready;

  qnor_walk u_walk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (accept),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .res_o       (walk_res)
  );

  assign new_word = '{node_handle_out: node_i.node_handle,
                      tensor_slot:     walk_res.slot,
                      last_node:       walk_res.last};

  always_comb begin
    main_d   = main_q;
    skid_d   = skid_q;
    main_v_d = main_v_q;
    skid_v_d = skid_v_q;
    if (skid_v_q) begin
      if (take) begin
        main_d   = skid_q;
        skid_v_d = 1'b0;
      end
    end else if (accept) begin
      if (!main_v_q || take) begin
        main_d   = new_word;
        main_v_d = 1'b1;
      end else begin
        // hold the new word aside while the output stalls
        skid_d   = new_word;
        skid_v_d = 1'b1;
      end
    end else if (take) begin
      main_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      main_v_q <= main_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  assign result_o.valid           = main_v_q;
  assign result_o.node_handle_out = main_q.node_handle_out;
  assign result_o.tensor_slot     = main_q.tensor_slot;
  assign result_o.last_node       = main_q.last_node;

endmodule

[hdl/qnor_chk.sv]
module qnor_chk
  import qnor_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_i,
  input logic [HANDLE_W-1:0] in_handle_i,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input logic [HANDLE_W-1:0] out_handle_i,
  input logic [SLOT_W-1:0]   out_slot_i,
  input logic                out_last_i,
  input logic                cfg_we_i
);

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_i;

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_handle_i)
      && $stable(out_slot_i) && $stable(out_last_i))
    else $error("result word changed under stall");

  // input closes only while a result word is waiting
  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i)
    else $error("input closed with empty output");

  // into an empty output stage a word appears next cycle, handle unchanged
  a_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !out_valid_i |=> out_valid_i && out_handle_i == $past(in_handle_i))
    else $error("handle not passed through");

  // first node after an order write lands in slot 0 and is not the last
  a_rewind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_we_i && !in_acc && !out_valid_i) ##1 (in_acc && !cfg_we_i)
      |=> out_slot_i == '0 && !out_last_i)
    else $error("walk not rewound by order write");

endmodule

bind quad_node_order_remap qnor_chk u_qnor_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (node_i.valid),
  .in_ready_i   (node_i.ready),
  .in_handle_i  (node_i.node_handle),
  .out_valid_i  (result_o.valid),
  .out_ready_i  (result_o.ready),
  .out_handle_i (result_o.node_handle_out),
  .out_slot_i   (result_o.tensor_slot),
  .out_last_i   (result_o.last_node),
  .cfg_we_i     (cfg_we_i)
);
